FILE: rtl/bucket_priority_queue_unit_macros.svh
// Assertion macros shared by the queue RTL
`ifndef BUCKET_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define BUCKET_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BPQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BPQ_ASSERT(label, clk, rst_n, prop, msg)
`define BPQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/bpq_pkg.sv
// Package: beat types, op codes, status codes and command structs
`timescale 1ns / 1ps
`default_nettype none
package bpq_pkg;
	localparam logic [1:0] MODE_INSERT    = 2'd0;
	localparam logic [1:0] MODE_REMOVE    = 2'd1;
	localparam logic [1:0] MODE_POP_FIRST = 2'd2;
	localparam logic [1:0] MODE_POP_LAST  = 2'd3;

	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_EMPTY      = 2'd1;
	localparam logic [1:0] ST_QUEUED     = 2'd2;
	localparam logic [1:0] ST_NOT_QUEUED = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] node_id;
		logic [5:0] weight;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] node_out;
		logic       found;
		logic [1:0] status;
	} out_beat_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the input beat, read bucket pointers
		logic pick;     // take pop target and old head from pointer RAMs
		logic decide;   // evaluate special cases, write own prev on insert
		logic commit;   // write neighbours, buckets and flags
	} bpq_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/bpq_ram.sv
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module bpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/bpq_datapath.sv
// Datapath: bucket pointers, node link memories, bitmap and result
`timescale 1ns / 1ps
`default_nettype none
`include "bucket_priority_queue_unit_macros.svh"
module bpq_datapath import bpq_pkg::*; #(
	parameter int NODE_COUNT    = 256,
	parameter int WEIGHT_LEVELS = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire bpq_cmd_t  cmd,
	input  wire in_beat_t  in_beat,
	output out_beat_t      result
);
	localparam int NW = $clog2(NODE_COUNT + 1);
	localparam int NA = $clog2(NODE_COUNT);
	localparam int BW = $clog2(WEIGHT_LEVELS);
	localparam logic [NW-1:0] NIL = NW'(NODE_COUNT);

	// bitmap and queued flags in flops with reset; bucket pointers in RAM
	// count as null while their map bit is clear
	logic [WEIGHT_LEVELS-1:0] map_q;
	logic [NODE_COUNT-1:0]    queued_q;

	logic [1:0]    mode_q;
	logic          id_ok_q;
	logic [NW-1:0] tgt_q;  // node being unlinked or linked
	logic [BW-1:0] b_q;    // bucket in use
	logic          act_q;  // an update is to be committed
	logic [NW-1:0] old_head_q;

	// bucket pointer memories
	logic          hd_we, tl_we;
	logic [BW-1:0] hd_wa, tl_wa, ht_ra;
	logic [NW-1:0] hd_wd, tl_wd, hd_rd, tl_rd;

	// link memories
	logic          nx_we, pv_we, bk_we;
	logic [NA-1:0] nx_wa, pv_wa, bk_wa, rd_a, tgt_a;
	logic [NW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic [BW-1:0] bk_wd, bk_rd;

	bpq_ram #(.WIDTH(NW), .DEPTH(WEIGHT_LEVELS)) u_head (.clk(clk), .we(hd_we),
		.waddr(hd_wa), .wdata(hd_wd), .raddr(ht_ra), .rdata(hd_rd));
	bpq_ram #(.WIDTH(NW), .DEPTH(WEIGHT_LEVELS)) u_tail (.clk(clk), .we(tl_we),
		.waddr(tl_wa), .wdata(tl_wd), .raddr(ht_ra), .rdata(tl_rd));
	bpq_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_next (.clk(clk), .we(nx_we),
		.waddr(nx_wa), .wdata(nx_wd), .raddr(rd_a), .rdata(nx_rd));
	bpq_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_prev (.clk(clk), .we(pv_we),
		.waddr(pv_wa), .wdata(pv_wd), .raddr(rd_a), .rdata(pv_rd));
	bpq_ram #(.WIDTH(BW), .DEPTH(NODE_COUNT)) u_bkt (.clk(clk), .we(bk_we),
		.waddr(bk_wa), .wdata(bk_wd), .raddr(rd_a), .rdata(bk_rd));

	// lowest non-empty bucket
	logic [BW-1:0] low_b;
	always_comb begin
		low_b = '0;
		for (int i = WEIGHT_LEVELS - 1; i >= 0; i--)
			if (map_q[i])
				low_b = BW'(i);
	end

	logic [BW-1:0] w_sat;
	assign w_sat = (7'(in_beat.weight) >= 7'(WEIGHT_LEVELS)) ? BW'(WEIGHT_LEVELS - 1)
		: BW'(in_beat.weight);

	logic pop_q;
	assign pop_q = mode_q[1];

	// pointer RAMs are addressed at capture so the bucket reads back in pick
	assign ht_ra = in_beat.mode[1] ? low_b : w_sat;
	assign tgt_a = NA'(tgt_q);
	assign rd_a  = tgt_a;

	logic [NW-1:0] pick_c;
	always_comb begin
		if (map_q == '0)
			pick_c = NIL;
		else if (mode_q == MODE_POP_FIRST)
			pick_c = hd_rd;
		else
			pick_c = tl_rd;
	end

	out_beat_t dec_res;
	logic      dec_act;
	always_comb begin
		dec_res = '0;
		dec_act = 1'b0;
		priority if (pop_q) begin
			if (tgt_q >= NIL)
				dec_res.status = ST_EMPTY;
			else begin
				dec_act = 1'b1;
				dec_res.node_out = 8'(tgt_q);
				dec_res.found = 1'b1;
			end
		end else if (!id_ok_q || (mode_q == MODE_REMOVE && !queued_q[tgt_a]))
			dec_res.status = ST_NOT_QUEUED;
		else if (mode_q == MODE_INSERT && queued_q[tgt_a])
			dec_res.status = ST_QUEUED;
		else
			dec_act = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q      <= '0;
			queued_q   <= '0;
			act_q      <= 1'b0;
			mode_q     <= MODE_INSERT;
			id_ok_q    <= 1'b0;
			tgt_q      <= NIL;
			b_q        <= '0;
			old_head_q <= NIL;
			result     <= '0;
		end else begin
			if (cmd.capture) begin
				mode_q  <= in_beat.mode;
				id_ok_q <= (32'(in_beat.node_id) < NODE_COUNT);
				tgt_q   <= NW'(in_beat.node_id);
				b_q     <= ht_ra;
				act_q   <= 1'b0;
			end
			if (cmd.pick) begin
				old_head_q <= map_q[b_q] ? hd_rd : NIL;
				if (pop_q)
					tgt_q <= pick_c;
			end
			if (cmd.decide) begin
				act_q  <= dec_act;
				result <= dec_res;
				if (dec_act && mode_q == MODE_REMOVE)
					b_q <= bk_rd;
			end
			if (cmd.commit && act_q) begin
				if (mode_q == MODE_INSERT) begin
					map_q[b_q] <= 1'b1;
					queued_q[tgt_a] <= 1'b1;
				end else begin
					if (pv_rd >= NIL && nx_rd >= NIL)
						map_q[b_q] <= 1'b0;
					queued_q[tgt_a] <= 1'b0;
				end
			end
		end
	end

	// decide writes own prev of an inserted node; commit sets own next,
	// bucket, head and old head's prev or tail, or patches neighbours on unlink
	logic own_c, ins_c, del_c;
	assign own_c = cmd.decide && dec_act && (mode_q == MODE_INSERT);
	assign ins_c = cmd.commit && act_q && (mode_q == MODE_INSERT);
	assign del_c = cmd.commit && act_q && (mode_q != MODE_INSERT);
	always_comb begin
		nx_we = 1'b0; pv_we = 1'b0; bk_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
		nx_wa = tgt_a; pv_wa = tgt_a; bk_wa = tgt_a; hd_wa = b_q; tl_wa = b_q;
		nx_wd = old_head_q; pv_wd = NIL; bk_wd = b_q; hd_wd = tgt_q; tl_wd = tgt_q;
		if (own_c) begin
			pv_we = 1'b1;
		end else if (ins_c) begin
			nx_we = 1'b1;
			bk_we = 1'b1;
			hd_we = 1'b1;
			if (old_head_q < NIL) begin
				pv_we = 1'b1; pv_wa = NA'(old_head_q); pv_wd = tgt_q;
			end else
				tl_we = 1'b1;
		end else if (del_c) begin
			if (nx_rd < NIL) begin
				pv_we = 1'b1; pv_wa = NA'(nx_rd); pv_wd = pv_rd;
			end else begin
				tl_we = 1'b1; tl_wd = pv_rd;
			end
			if (pv_rd < NIL) begin
				nx_we = 1'b1; nx_wa = NA'(pv_rd); nx_wd = nx_rd;
			end else begin
				hd_we = 1'b1; hd_wd = nx_rd;
			end
		end
	end

	`BPQ_ASSERT(a_one_cmd, clk, arst_n, $onehot0({cmd.capture, cmd.pick, cmd.decide, cmd.commit}),
		"more than one command at once")
	`BPQ_ASSERT(a_found_done, clk, arst_n, !result.found || (result.status == ST_DONE),
		"popped node with failing status")
	`BPQ_ASSERT_NEXT(a_ins_map, clk, arst_n, ins_c, map_q[b_q],
		"insert left bucket empty")
endmodule
`default_nettype wire

FILE: rtl/bpq_ctrl.sv
// Controller: sequences capture, pick, link read, decide, commit and result
`timescale 1ns / 1ps
`default_nettype none
`include "bucket_priority_queue_unit_macros.svh"
module bpq_ctrl import bpq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output bpq_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PICK = 3'd1;
	localparam logic [2:0] S_LINK = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_COM  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	always_comb begin
		cmd = '0;
		cmd.capture = in_valid && in_ready;
		cmd.pick    = (state_q == S_PICK);
		cmd.decide  = (state_q == S_DEC);
		cmd.commit  = (state_q == S_COM);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_PICK;
				S_PICK: state_q <= S_LINK;
				S_LINK: state_q <= S_DEC;
				S_DEC:  state_q <= S_COM;
				S_COM:  state_q <= S_OUT;
				S_OUT:  if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BPQ_ASSERT_NEXT(a_cap_pick, clk, arst_n, cmd.capture, state_q == S_PICK,
		"capture not followed by pick")
	`BPQ_ASSERT(a_no_overlap, clk, arst_n, !(in_ready && out_valid),
		"ready while result pending")
	`BPQ_ASSERT_NEXT(a_com_out, clk, arst_n, cmd.commit, out_valid,
		"commit not followed by result")
endmodule
`default_nettype wire

FILE: rtl/bucket_priority_queue_unit.sv
// Top level: bucket priority queue of node ids keyed by weight
// The result beat is valid once pick, link read, decide and commit have run after the input beat is taken.
// A new input beat is taken only once the previous result is accepted; one item at a time.
// Pointer and link RAMs have registered reads: pick, link read, decide, commit in turn.
// Reset: arst_n clears the bitmap and queued flags at once, with no clearing pass;
// a bucket with its map bit clear reads as null, links are read for queued nodes only.
`timescale 1ns / 1ps
`default_nettype none
module bucket_priority_queue_unit import bpq_pkg::*; #(
	parameter int NODE_COUNT    = 256,
	parameter int WEIGHT_LEVELS = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_beat_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_beat_t     out_data
);
	bpq_cmd_t cmd;

	// control sequence
	bpq_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd));

	// storage and update logic
	bpq_datapath #(.NODE_COUNT(NODE_COUNT), .WEIGHT_LEVELS(WEIGHT_LEVELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_beat(in_data),
		.result(out_data));
endmodule
`default_nettype wire
